/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files of the positional insert/delete array
// depends on nothing; the including module must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PIDA_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PIDA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/pida_pkg.sv */
// types and codes of the positional insert/delete array
// depends on nothing; used by pida_mem and positional_insert_delete_array_top
`default_nettype none

package pida_pkg;

    localparam int WORD_W = 32;

    // operation codes of a request
    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_INSERT    = 3'd2,
        OP_ERASE_ONE = 3'd3,
        OP_ERASE_RNG = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_ACCESS    = 3'd6
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_PUT  = 5'b00100,
        S_DOWN = 5'b01000,
        S_RD   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/pida_mem.sv */
// entry store: one write port and one registered read port
// depends on pida_pkg for the word width
`default_nettype none

module pida_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                        clk,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [pida_pkg::WORD_W-1:0] rd_data,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [pida_pkg::WORD_W-1:0] wr_data
);

    logic [pida_pkg::WORD_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/positional_insert_delete_array_top.sv */
// top level of the positional insert/delete array: request decode and shift sequencer
// depends on pida_pkg, pida_mem and assert_macros.svh
`default_nettype none

// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off.
// Append, remove last, clear, write and every refused request answer in the
// cycle after start without raising busy. A read waits in S_RD for the
// registered store data. Insert moves the entries from position to the end up
// one slot in S_UP, one entry per cycle through the store's one read port and
// one write port, then drops the new word in S_PUT; an insert at the end is an
// append and answers without raising busy. Erase moves the entries behind the
// erased ones down in S_DOWN, one per cycle, so erasing the tail moves nothing
// and answers without raising busy. Clear only resets the element count; slots
// beyond the count are never read, so no clearing pass runs after reset.

`include "assert_macros.svh"

module positional_insert_delete_array_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  op,
    input  wire logic               write_enable,
    input  wire logic        [4:0]  position,
    input  wire logic        [3:0]  range_end,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic signed [31:0]      read_word,
    output logic             [4:0]  count,
    output logic             [1:0]  status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    pida_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 cursor_reg, cursor_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [XW-1:0]                 gap_reg, gap_next;
    logic [pida_pkg::WORD_W-1:0]   value_reg, value_next;
    logic                          done_reg, done_next;
    logic [pida_pkg::WORD_W-1:0]   read_word_reg, read_word_next;
    pida_pkg::status_t             status_reg, status_next;

    logic [AW-1:0]                 mem_rd_addr;
    logic [pida_pkg::WORD_W-1:0]   mem_rd_data;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic [pida_pkg::WORD_W-1:0]   mem_wr_data;

    logic [XW-1:0]                 cnt_x;
    logic [XW-1:0]                 pos_x;
    logic [XW-1:0]                 last_x;
    logic [XW-1:0]                 gap_x;
    logic [XW-1:0]                 src_x;
    logic                          is_full;
    logic                          is_empty;

    logic                          clear_taken;
    logic                          empty_answer;
    logic                          read_ending;

    // entry store
    pida_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // common index arithmetic in one width
    assign cnt_x    = XW'(count_reg);
    assign pos_x    = XW'(position);
    assign last_x   = (op == pida_pkg::OP_ERASE_ONE) ? pos_x : XW'(range_end);
    assign gap_x    = last_x - pos_x + XW'(1);
    assign src_x    = last_x + XW'(1);
    assign is_full  = (cnt_x == XW'(CAPACITY));
    assign is_empty = (cnt_x == '0);

    // request decode and shift sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        pos_next       = pos_reg;
        gap_next       = gap_reg;
        value_next     = value_reg;
        done_next      = 1'b0;
        read_word_next = '0;
        status_next    = pida_pkg::ST_OK;
        mem_rd_addr    = cursor_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cursor_reg;
        mem_wr_data    = value;

        unique case (state_reg)
            pida_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (pida_pkg::op_t'(op))
                        pida_pkg::OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = pida_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(count_reg);
                                count_next  = CW'(cnt_x + XW'(1));
                            end
                        end
                        pida_pkg::OP_REMOVE:
                        begin
                            done_next = 1'b1;
                            if (is_empty)
                            begin
                                status_next = pida_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = CW'(cnt_x - XW'(1));
                            end
                        end
                        pida_pkg::OP_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                done_next   = 1'b1;
                                status_next = pida_pkg::ST_BADIDX;
                            end
                            else if (is_full)
                            begin
                                done_next   = 1'b1;
                                status_next = pida_pkg::ST_FULL;
                            end
                            else if (pos_x == cnt_x)
                            begin
                                done_next   = 1'b1;
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(pos_x);
                                count_next  = CW'(cnt_x + XW'(1));
                            end
                            else
                            begin
                                mem_rd_addr = AW'(cnt_x - XW'(1));
                                cursor_next = AW'(cnt_x - XW'(1));
                                pos_next    = AW'(pos_x);
                                value_next  = value;
                                state_next  = pida_pkg::S_UP;
                            end
                        end
                        pida_pkg::OP_ERASE_ONE, pida_pkg::OP_ERASE_RNG:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = pida_pkg::ST_EMPTY;
                            end
                            else if (pos_x > last_x || last_x >= cnt_x)
                            begin
                                done_next   = 1'b1;
                                status_next = pida_pkg::ST_BADIDX;
                            end
                            else if (src_x == cnt_x)
                            begin
                                done_next  = 1'b1;
                                count_next = CW'(cnt_x - gap_x);
                            end
                            else
                            begin
                                mem_rd_addr = AW'(src_x);
                                cursor_next = AW'(src_x);
                                gap_next    = gap_x;
                                state_next  = pida_pkg::S_DOWN;
                            end
                        end
                        pida_pkg::OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        pida_pkg::OP_ACCESS:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = pida_pkg::ST_EMPTY;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                done_next   = 1'b1;
                                status_next = pida_pkg::ST_BADIDX;
                            end
                            else if (write_enable)
                            begin
                                done_next   = 1'b1;
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(pos_x);
                            end
                            else
                            begin
                                mem_rd_addr = AW'(pos_x);
                                state_next  = pida_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // move one entry up per cycle, from the end down to position
            pida_pkg::S_UP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cursor_reg + AW'(1);
                mem_wr_data = mem_rd_data;
                if (cursor_reg == pos_reg)
                begin
                    state_next = pida_pkg::S_PUT;
                end
                else
                begin
                    cursor_next = cursor_reg - AW'(1);
                    mem_rd_addr = cursor_reg - AW'(1);
                end
            end

            // drop the new word into the opened slot
            pida_pkg::S_PUT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg;
                mem_wr_data = value_reg;
                count_next  = CW'(cnt_x + XW'(1));
                done_next   = 1'b1;
                state_next  = pida_pkg::S_IDLE;
            end

            // move one entry down by the gap per cycle, up to the end
            pida_pkg::S_DOWN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(XW'(cursor_reg) - gap_reg);
                mem_wr_data = mem_rd_data;
                if (XW'(cursor_reg) + XW'(1) == cnt_x)
                begin
                    count_next = CW'(cnt_x - gap_reg);
                    done_next  = 1'b1;
                    state_next = pida_pkg::S_IDLE;
                end
                else
                begin
                    cursor_next = cursor_reg + AW'(1);
                    mem_rd_addr = cursor_reg + AW'(1);
                end
            end

            // read data is back from the store
            pida_pkg::S_RD:
            begin
                read_word_next = mem_rd_data;
                done_next      = 1'b1;
                state_next     = pida_pkg::S_IDLE;
            end

            default:
            begin
                state_next = pida_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pida_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cursor_reg    <= cursor_next;
        pos_reg       <= pos_next;
        gap_reg       <= gap_next;
        value_reg     <= value_next;
        read_word_reg <= read_word_next;
        status_reg    <= status_next;
    end

    // outputs
    assign busy      = (state_reg != pida_pkg::S_IDLE);
    assign done      = done_reg;
    assign read_word = read_word_reg;
    assign count     = cnt_x[4:0];
    assign status    = status_reg;

    // conditions watched by the checks
    assign clear_taken  = start && !busy && (op == pida_pkg::OP_CLEAR);
    assign empty_answer = done_reg && (status_reg == pida_pkg::ST_EMPTY);
    assign read_ending  = (state_reg == pida_pkg::S_RD);

    // checks
    `PIDA_ASSERT_NEXT(a_clear_one_cycle, clear_taken, done && count_reg == '0, "clear not answered")
    `PIDA_ASSERT_IMPLY(a_empty_status, empty_answer, count_reg == '0, "empty status with entries")
    `PIDA_ASSERT_IMPLY(a_no_write_on_read, read_ending, !mem_wr_en, "store written during a read")
    `PIDA_ASSERT_IMPLY(a_count_bound, 1'b1, cnt_x <= XW'(CAPACITY), "count above capacity")

endmodule

`default_nettype wire
